FILE: rtl/sdra_pkg.sv
// ----------------------------------------------------------------------------
// sdra_pkg
// Types, constants and helpers shared by the spring-damper RK4 animator.
// ----------------------------------------------------------------------------
package sdra_pkg;

	localparam int VAL_W        = 32;
	localparam int PH_W         = 27;
	localparam int TT_W         = 17;
	localparam int ONE_Q16      = 65536;
	localparam int ACC_W        = 36;
	localparam int MA_W         = 36;
	localparam int MB_W         = 32;
	localparam int PROD_W       = MA_W + MB_W;
	localparam int SPR_W        = 48;
	localparam int DIV_W        = 37;
	localparam int D6_LO_W      = 16;
	localparam int D6_W         = 23;
	localparam int D6_M_W       = 22;
	localparam int D6_SH        = 24;
	localparam int D6_Q_W       = DIV_W - D6_LO_W;
	localparam int MS_W         = 10;
	localparam int MAX_DELTA_MS = 1000;
	localparam int SPM_W        = 16;
	localparam int H_W          = 24;
	localparam int K_W          = 31;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	// ceil(2^24 / 6): exact quotient for inputs below 2^23
	localparam logic [D6_M_W-1:0] DIV6_MUL = 22'd2796203;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ACT_ADVANCE = 2'd0,
		ACT_SET_POS = 2'd1,
		ACT_SET_VEL = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANCHOR  = 3'd0,
		CFG_EPSILON = 3'd1,
		CFG_SPRING  = 3'd2,
		CFG_DAMPING = 3'd3,
		CFG_STEP    = 3'd4,
		CFG_RATE    = 3'd5,
		CFG_SNAP    = 3'd6
	} cfg_idx_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_MUL_LPOS,
		DP_APP_LPOS,
		DP_MUL_LVEL,
		DP_APP_LVEL,
		DP_SET_POS,
		DP_SET_VEL,
		DP_SNAP,
		DP_PHASE_ADD,
		DP_STEP_INIT,
		DP_MUL_NP,
		DP_APP_NP,
		DP_MUL_NV,
		DP_APP_NV,
		DP_MUL_SPR,
		DP_APP_SPR,
		DP_MUL_DMP,
		DP_APP_DMP,
		DP_MUL_FP,
		DP_MUL_FV,
		DP_LOAD_DIV,
		DP_DIV_HI,
		DP_DIV_LO,
		DP_FIN_P,
		DP_FIN_V,
		DP_COMMIT,
		DP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LP_M,
		S_LP_A,
		S_LV_M,
		S_LV_A,
		S_DISPATCH,
		S_PH,
		S_CHK,
		S_INIT,
		S_NP_M,
		S_NP_A,
		S_NV_M,
		S_NV_A,
		S_SPR_M,
		S_SPR_A,
		S_DMP_M,
		S_DMP_A,
		S_FP_M,
		S_FP_L,
		S_FP_DH,
		S_FP_DL,
		S_FP_F,
		S_FV_M,
		S_FV_L,
		S_FV_DH,
		S_FV_DL,
		S_FV_F,
		S_COMMIT,
		S_OUT
	} ctl_state_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] stage;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       moving;
		logic       snap;
		logic       phase_gt_one;
	} dp_stat_t;

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] x);
		if (x > 64'(VAL_MAX))
			return VAL_MAX;
		if (x < 64'(VAL_MIN))
			return VAL_MIN;
		return VAL_W'(x);
	endfunction

endpackage

FILE: rtl/sdra_datapath.sv
// ----------------------------------------------------------------------------
// sdra_datapath
// Registers, shared multiplier, reciprocal divide-by-six and config registers.
// ----------------------------------------------------------------------------
module sdra_datapath import sdra_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                stat,
	input  logic [1:0]              action,
	input  logic [MS_W-1:0]         delta_ms,
	input  logic signed [VAL_W-1:0] set_value,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic signed [VAL_W-1:0] position_out,
	output logic signed [VAL_W-1:0] velocity_out,
	output logic                    moving
);

	logic signed [VAL_W-1:0] anchor_q;
	logic [K_W-1:0]          eps_q, k_q, c_q;
	logic [H_W-1:0]          h_q;
	logic [SPM_W-1:0]        spm_q;
	logic                    snap_q;

	logic signed [VAL_W-1:0] prev_p_q, prev_v_q, next_p_q, next_v_q;
	logic [PH_W-1:0]         phase_q;

	logic [1:0]              action_q;
	logic [MS_W-1:0]         ms_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] cur_p_q, cur_v_q, np_q, nv_q, dp_q, dv_q, new_p_q, new_v_q;
	logic signed [SPR_W-1:0] spr_q;
	logic signed [ACC_W-1:0] acc_p_q, acc_v_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [DIV_W-1:0]        div_u_q;
	logic [2:0]              div_r_q;
	logic                    div_neg_q;

	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic [TT_W-1:0]          tt;
	logic signed [PROD_W-1:0] rnd16, rnd_h, div_y;
	logic signed [VAL_W-1:0]  off_s, dmp_new, fin_val;
	logic signed [63:0]       quo;
	logic signed [VAL_W:0]    off_c, vel_c;
	logic [VAL_W:0]           off_abs, vel_abs;
	logic                     mov;
	logic [D6_W-1:0]          d6_in, d6_back, d6_rem;
	logic [D6_W+D6_M_W-1:0]   d6_prod;
	logic [D6_Q_W-1:0]        d6_q;
	logic [MS_W-1:0]          ms_c;
	logic signed [ACC_W-1:0]  w_nv, w_dv;

	assign tt = (phase_q > PH_W'(ONE_Q16)) ? TT_W'(ONE_Q16) : phase_q[TT_W-1:0];
	assign ms_c = (ms_q > MS_W'(MAX_DELTA_MS)) ? MS_W'(MAX_DELTA_MS) : ms_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			DP_MUL_LPOS: begin
				mul_a = MA_W'(next_p_q) - MA_W'(prev_p_q);
				mul_b = MB_W'(tt);
			end
			DP_MUL_LVEL: begin
				mul_a = MA_W'(next_v_q) - MA_W'(prev_v_q);
				mul_b = MB_W'(tt);
			end
			DP_MUL_NP: begin
				mul_a = MA_W'(dp_q);
				mul_b = MB_W'(h_q);
			end
			DP_MUL_NV: begin
				mul_a = MA_W'(dv_q);
				mul_b = MB_W'(h_q);
			end
			DP_MUL_SPR: begin
				mul_a = MA_W'(off_s);
				mul_b = MB_W'(k_q);
			end
			DP_MUL_DMP: begin
				mul_a = MA_W'(nv_q);
				mul_b = MB_W'(c_q);
			end
			DP_MUL_FP: begin
				mul_a = acc_p_q;
				mul_b = MB_W'(h_q);
			end
			DP_MUL_FV: begin
				mul_a = acc_v_q;
				mul_b = MB_W'(h_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// rounding half up is add-half then arithmetic shift
	assign rnd16 = (prod_q + PROD_W'(32768)) >>> 16;
	assign rnd_h = (cmd.stage == 2'd3) ? ((prod_q + (PROD_W'(1) <<< 23)) >>> 24)
	                                   : ((prod_q + (PROD_W'(1) <<< 24)) >>> 25);
	assign off_s = sat_val(64'(anchor_q) - 64'(np_q));
	assign dmp_new = sat_val(64'(spr_q) - 64'(rnd16));
	assign w_nv = (cmd.stage == 2'd1 || cmd.stage == 2'd2) ? (ACC_W'(nv_q) <<< 1) : ACC_W'(nv_q);
	assign w_dv = (cmd.stage == 2'd1 || cmd.stage == 2'd2) ? (ACC_W'(dmp_new) <<< 1)
	                                                       : ACC_W'(dmp_new);

	// rounding divide by 6*2^24 (half up): add half and shift first, then divide magnitude by 6
	// in two halves, upper bits first, remainder carried into the lower half
	assign div_y = (prod_q + (PROD_W'(3) <<< 24)) >>> 24;
	assign d6_in = (cmd.op == DP_DIV_LO) ? D6_W'({div_r_q, div_u_q[D6_LO_W-1:0]})
	                                     : D6_W'(div_u_q[DIV_W-1:D6_LO_W]);
	assign d6_prod = (D6_W+D6_M_W)'(d6_in) * (D6_W+D6_M_W)'(DIV6_MUL);
	assign d6_q = d6_prod[D6_SH +: D6_Q_W];
	assign d6_back = (D6_W'(d6_q) << 2) + (D6_W'(d6_q) << 1);
	assign d6_rem = d6_in - d6_back;
	assign quo = div_neg_q ? -$signed(64'(div_u_q)) : $signed(64'(div_u_q));
	assign fin_val = sat_val(64'(next_p_q) + quo);

	assign off_c = (VAL_W+1)'(cur_p_q) - (VAL_W+1)'(anchor_q);
	assign vel_c = (VAL_W+1)'(cur_v_q);
	assign off_abs = off_c[VAL_W] ? unsigned'(-off_c) : unsigned'(off_c);
	assign vel_abs = vel_c[VAL_W] ? unsigned'(-vel_c) : unsigned'(vel_c);
	assign mov = (off_abs > (VAL_W+1)'(eps_q)) || (vel_abs > (VAL_W+1)'(eps_q));

	assign stat.action = action_q;
	assign stat.moving = mov;
	assign stat.snap = snap_q;
	assign stat.phase_gt_one = phase_q > PH_W'(ONE_Q16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q <= '0;
			eps_q    <= K_W'(65536);
			k_q      <= K_W'(13107200);
			c_q      <= K_W'(2039034);
			h_q      <= H_W'(167772);
			spm_q    <= SPM_W'(6554);
			snap_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ANCHOR:  anchor_q <= $signed(cfg_data[VAL_W-1:0]);
				CFG_EPSILON: eps_q    <= cfg_data[K_W-1:0];
				CFG_SPRING:  k_q      <= cfg_data[K_W-1:0];
				CFG_DAMPING: c_q      <= cfg_data[K_W-1:0];
				CFG_STEP:    h_q      <= cfg_data[H_W-1:0];
				CFG_RATE:    spm_q    <= cfg_data[SPM_W-1:0];
				CFG_SNAP:    snap_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_p_q <= '0;
			prev_v_q <= '0;
			next_p_q <= '0;
			next_v_q <= '0;
			phase_q  <= PH_W'(ONE_Q16);
		end else begin
			unique case (cmd.op)
				DP_SET_POS: begin
					next_p_q <= val_q;
					next_v_q <= cur_v_q;
					phase_q  <= PH_W'(ONE_Q16);
				end
				DP_SET_VEL: begin
					next_p_q <= cur_p_q;
					next_v_q <= val_q;
					phase_q  <= PH_W'(ONE_Q16);
				end
				DP_SNAP: begin
					next_p_q <= anchor_q;
					next_v_q <= '0;
				end
				DP_PHASE_ADD: phase_q <= phase_q + PH_W'(ms_c) * PH_W'(spm_q);
				DP_COMMIT: begin
					prev_p_q <= next_p_q;
					prev_v_q <= next_v_q;
					next_p_q <= new_p_q;
					next_v_q <= new_v_q;
					phase_q  <= phase_q - PH_W'(ONE_Q16);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		unique case (cmd.op)
			DP_LOAD: begin
				action_q <= action;
				ms_q     <= delta_ms;
				val_q    <= set_value;
			end
			DP_APP_LPOS: cur_p_q <= prev_p_q + rnd16[VAL_W-1:0];
			DP_APP_LVEL: cur_v_q <= prev_v_q + rnd16[VAL_W-1:0];
			DP_STEP_INIT: begin
				np_q    <= next_p_q;
				nv_q    <= next_v_q;
				acc_p_q <= '0;
				acc_v_q <= '0;
			end
			DP_APP_NP: np_q <= sat_val(64'(next_p_q) + 64'(rnd_h));
			DP_APP_NV: nv_q <= sat_val(64'(next_v_q) + 64'(rnd_h));
			DP_APP_SPR: spr_q <= SPR_W'(rnd16);
			DP_APP_DMP: begin
				dp_q    <= nv_q;
				dv_q    <= dmp_new;
				acc_p_q <= acc_p_q + w_nv;
				acc_v_q <= acc_v_q + w_dv;
			end
			DP_LOAD_DIV: begin
				div_neg_q <= div_y < 0;
				div_u_q   <= (div_y < 0) ? DIV_W'(-div_y + PROD_W'(5)) : DIV_W'(div_y);
				div_r_q   <= '0;
			end
			DP_DIV_HI: begin
				div_u_q <= {d6_q, div_u_q[D6_LO_W-1:0]};
				div_r_q <= d6_rem[2:0];
			end
			DP_DIV_LO: div_u_q <= {div_u_q[DIV_W-1:D6_LO_W], d6_q[D6_LO_W-1:0]};
			DP_FIN_P: new_p_q <= fin_val;
			DP_FIN_V: new_v_q <= sat_val(64'(next_v_q) + quo);
			DP_OUT: begin
				position_out <= cur_p_q;
				velocity_out <= cur_v_q;
				moving       <= mov;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/sdra_ctrl.sv
// ----------------------------------------------------------------------------
// sdra_ctrl
// Sequencer: interpolation, action dispatch, RK4 stages, divide and commit.
// ----------------------------------------------------------------------------
module sdra_ctrl import sdra_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctl_state_t           state_q, state_d;
	logic [1:0]           stage_q, stage_d;
	logic                 fin_q, fin_d;
	logic                 out_valid_q, out_valid_d;

	assign out_valid = out_valid_q;
	assign cmd.stage = stage_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stage_q     <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			stage_q     <= stage_d;
			fin_q       <= fin_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		stage_d     = stage_q;
		fin_d       = fin_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd.op      = DP_NOP;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = DP_LOAD;
					fin_d   = 1'b0;
					state_d = S_LP_M;
				end
			end
			S_LP_M: begin
				cmd.op  = DP_MUL_LPOS;
				state_d = S_LP_A;
			end
			S_LP_A: begin
				cmd.op  = DP_APP_LPOS;
				state_d = S_LV_M;
			end
			S_LV_M: begin
				cmd.op  = DP_MUL_LVEL;
				state_d = S_LV_A;
			end
			S_LV_A: begin
				cmd.op  = DP_APP_LVEL;
				state_d = fin_q ? S_OUT : S_DISPATCH;
			end
			S_DISPATCH: begin
				fin_d   = 1'b1;
				state_d = S_LP_M;
				case (action_t'(stat.action))
					ACT_ADVANCE: begin
						if (stat.moving && stat.snap)
							cmd.op = DP_SNAP;
						else if (stat.moving)
							state_d = S_PH;
					end
					ACT_SET_POS: cmd.op = DP_SET_POS;
					ACT_SET_VEL: cmd.op = DP_SET_VEL;
					default: ;
				endcase
			end
			S_PH: begin
				cmd.op  = DP_PHASE_ADD;
				state_d = S_CHK;
			end
			S_CHK: state_d = stat.phase_gt_one ? S_INIT : S_LP_M;
			S_INIT: begin
				cmd.op  = DP_STEP_INIT;
				stage_d = '0;
				state_d = S_SPR_M;
			end
			S_NP_M: begin
				cmd.op  = DP_MUL_NP;
				state_d = S_NP_A;
			end
			S_NP_A: begin
				cmd.op  = DP_APP_NP;
				state_d = S_NV_M;
			end
			S_NV_M: begin
				cmd.op  = DP_MUL_NV;
				state_d = S_NV_A;
			end
			S_NV_A: begin
				cmd.op  = DP_APP_NV;
				state_d = S_SPR_M;
			end
			S_SPR_M: begin
				cmd.op  = DP_MUL_SPR;
				state_d = S_SPR_A;
			end
			S_SPR_A: begin
				cmd.op  = DP_APP_SPR;
				state_d = S_DMP_M;
			end
			S_DMP_M: begin
				cmd.op  = DP_MUL_DMP;
				state_d = S_DMP_A;
			end
			S_DMP_A: begin
				cmd.op = DP_APP_DMP;
				if (stage_q == 2'd3) begin
					state_d = S_FP_M;
				end else begin
					stage_d = stage_q + 2'd1;
					state_d = S_NP_M;
				end
			end
			S_FP_M: begin
				cmd.op  = DP_MUL_FP;
				state_d = S_FP_L;
			end
			S_FP_L: begin
				cmd.op  = DP_LOAD_DIV;
				state_d = S_FP_DH;
			end
			S_FP_DH: begin
				cmd.op  = DP_DIV_HI;
				state_d = S_FP_DL;
			end
			S_FP_DL: begin
				cmd.op  = DP_DIV_LO;
				state_d = S_FP_F;
			end
			S_FP_F: begin
				cmd.op  = DP_FIN_P;
				state_d = S_FV_M;
			end
			S_FV_M: begin
				cmd.op  = DP_MUL_FV;
				state_d = S_FV_L;
			end
			S_FV_L: begin
				cmd.op  = DP_LOAD_DIV;
				state_d = S_FV_DH;
			end
			S_FV_DH: begin
				cmd.op  = DP_DIV_HI;
				state_d = S_FV_DL;
			end
			S_FV_DL: begin
				cmd.op  = DP_DIV_LO;
				state_d = S_FV_F;
			end
			S_FV_F: begin
				cmd.op  = DP_FIN_V;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.op  = DP_COMMIT;
				state_d = S_CHK;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = DP_OUT;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: rtl/spring_damper_rk4_animator.sv
// ----------------------------------------------------------------------------
// spring_damper_rk4_animator
// Mass-spring-damper animation with fixed-step RK4 integration, Q16.16.
// ----------------------------------------------------------------------------
// One word is processed at a time; in_ready is high only while idle. Set words,
// unknown actions and advance words on a still or snapping motion load their
// result after interpolation, dispatch and a second interpolation. A moving
// advance word takes whole RK4 steps (four stages on one shared multiplier,
// then two reciprocal divides by six); the phase gains delta_ms * steps_per_ms
// and a step is taken while it stays above 1.0, so up to about 1000 steps at
// the largest rate. The next word is taken in the cycle after a result is
// loaded; the result register holds it until out_ready while the next word
// is worked. Config writes are taken at any time and belong between words.
module spring_damper_rk4_animator import sdra_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              action,
	input  logic [MS_W-1:0]         delta_ms,
	input  logic signed [VAL_W-1:0] set_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] position_out,
	output logic signed [VAL_W-1:0] velocity_out,
	output logic                    moving,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	sdra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sdra_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.delta_ms     (delta_ms),
		.set_value    (set_value),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.position_out (position_out),
		.velocity_out (velocity_out),
		.moving       (moving)
	);

endmodule

FILE: rtl/sdra_checker.sv
// ----------------------------------------------------------------------------
// sdra_checker
// Port-level checks of the animator, bound to the top level.
// ----------------------------------------------------------------------------
module sdra_checker import sdra_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [VAL_W-1:0] position_out,
	input logic                    moving
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(position_out) && $stable(moving))
		else $error("result word changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a word in work");

endmodule

bind spring_damper_rk4_animator sdra_checker u_sdra_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.position_out (position_out),
	.moving       (moving)
);

FILE: tb/sv/spring_damper_rk4_animator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_damper_rk4_animator_test
// Self-checking bench for the RK4 spring-damper animator. Words are sent with
// random bursts and gaps; a built-in fixed-point model of the animator
// predicts position, velocity and the moving flag for every accepted word,
// and a checker compares each returned word against the oldest prediction.
// ----------------------------------------------------------------------------
module spring_damper_rk4_animator_test;
	import sdra_pkg::*;

	localparam logic [1:0] ACT_UNKNOWN = 2'd3;
	localparam longint Q_ONE = 65536;

	typedef struct {
		logic signed [VAL_W-1:0] pos;
		logic signed [VAL_W-1:0] vel;
		logic                    mov;
	} motion_word_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              action;
	logic [MS_W-1:0]         delta_ms;
	logic signed [VAL_W-1:0] set_value;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [VAL_W-1:0] position_out;
	logic signed [VAL_W-1:0] velocity_out;
	logic                    moving;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	spring_damper_rk4_animator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .delta_ms(delta_ms), .set_value(set_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.position_out(position_out), .velocity_out(velocity_out), .moving(moving),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// model registers and state
	longint r_anchor, r_eps, r_k, r_c, r_h, r_rate, r_snap;
	longint s_prev_pos, s_prev_vel, s_next_pos, s_next_vel, s_phase;

	motion_word_t expected_motion[$];
	int fail_count;
	int burst_left;
	bit no_gaps;
	bit no_stall;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#500_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// divide rounding half up, d > 0
	function automatic longint round_div(longint x, longint d);
		longint y, q;
		y = x + d / 2;
		q = y / d;
		if (y % d != 0 && y < 0)
			q--;
		return q;
	endfunction

	function automatic longint blend(longint a, longint b);
		longint tt;
		tt = (s_phase > Q_ONE) ? Q_ONE : s_phase;
		return round_div(a * (Q_ONE - tt) + b * tt, Q_ONE);
	endfunction

	function automatic longint now_pos();
		return blend(s_prev_pos, s_next_pos);
	endfunction

	function automatic longint now_vel();
		return blend(s_prev_vel, s_next_vel);
	endfunction

	function automatic bit in_motion();
		longint off, vel;
		off = now_pos() - r_anchor;
		vel = now_vel();
		if (off < 0)
			off = -off;
		if (vel < 0)
			vel = -vel;
		return (off > r_eps) || (vel > r_eps);
	endfunction

	task automatic slope(input longint p, input longint v, input longint dp, input longint dv,
			input longint dt, input int shift, output longint odp, output longint odv);
		longint den, np, nv, off;
		den = longint'(1) << shift;
		np = clamp32(p + round_div(dp * dt, den));
		nv = clamp32(v + round_div(dv * dt, den));
		off = clamp32(r_anchor - np);
		odp = nv;
		odv = clamp32(round_div(off * r_k, Q_ONE) - round_div(nv * r_c, Q_ONE));
	endtask

	task automatic integrate_step();
		longint p, v, p1, v1, p2, v2, p3, v3, p4, v4, sp, sv;
		p = s_next_pos;
		v = s_next_vel;
		slope(p, v, 0, 0, 0, 24, p1, v1);
		slope(p, v, p1, v1, r_h, 25, p2, v2);
		slope(p, v, p2, v2, r_h, 25, p3, v3);
		slope(p, v, p3, v3, r_h, 24, p4, v4);
		sp = p1 + 2 * p2 + 2 * p3 + p4;
		sv = v1 + 2 * v2 + 2 * v3 + v4;
		s_prev_pos = s_next_pos;
		s_prev_vel = s_next_vel;
		s_next_pos = clamp32(p + round_div(sp * r_h, longint'(6) << 24));
		s_next_vel = clamp32(v + round_div(sv * r_h, longint'(6) << 24));
	endtask

	task automatic predict_motion(input logic [1:0] act, input logic [MS_W-1:0] ms,
			input logic signed [VAL_W-1:0] val);
		longint t, keep;
		motion_word_t w;
		if (act == ACT_ADVANCE) begin
			t = (ms > MAX_DELTA_MS) ? MAX_DELTA_MS : ms;
			if (in_motion()) begin
				if (r_snap != 0) begin
					s_next_pos = r_anchor;
					s_next_vel = 0;
				end else begin
					s_phase += t * r_rate;
					while (s_phase > Q_ONE) begin
						integrate_step();
						s_phase -= Q_ONE;
					end
				end
			end
		end else if (act == ACT_SET_POS) begin
			keep = now_vel();
			s_next_pos = val;
			s_next_vel = keep;
			s_phase = Q_ONE;
		end else if (act == ACT_SET_VEL) begin
			keep = now_pos();
			s_next_pos = keep;
			s_next_vel = val;
			s_phase = Q_ONE;
		end
		w.pos = VAL_W'(now_pos());
		w.vel = VAL_W'(now_vel());
		w.mov = in_motion();
		expected_motion.push_back(w);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		motion_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_motion.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				w = expected_motion.pop_front();
				if (position_out !== w.pos)
					report_mismatch("position_out", position_out, w.pos);
				if (velocity_out !== w.vel)
					report_mismatch("velocity_out", velocity_out, w.vel);
				if (moving !== w.mov)
					report_mismatch("moving", moving, w.mov);
			end
		end
	end

	always @(negedge clk) begin
		if (no_stall)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 9) < 6);
	end

	// called at a falling edge; returns at a falling edge
	task automatic send_word(input logic [1:0] act, input logic [MS_W-1:0] ms,
			input logic signed [VAL_W-1:0] val);
		int gap;
		in_valid <= 1'b1;
		action <= act;
		delta_ms <= ms;
		set_value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_motion(act, ms, val);
		@(negedge clk);
		if (!no_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 8);
				gap = $urandom_range(1, 6);
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_motion.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_ANCHOR:  r_anchor = longint'(signed'(data));
			CFG_EPSILON: r_eps = data[30:0];
			CFG_SPRING:  r_k = data[30:0];
			CFG_DAMPING: r_c = data[30:0];
			CFG_STEP:    r_h = data[23:0];
			CFG_RATE:    r_rate = data[15:0];
			CFG_SNAP:    r_snap = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_directed_defaults();
		send_word(ACT_ADVANCE, 10'd100, 32'sd0);
		send_word(ACT_SET_POS, 10'd0, 32'sh0005_0000);
		send_word(ACT_ADVANCE, 10'd0, 32'sd0);
		send_word(ACT_ADVANCE, 10'd16, 32'sd0);
		send_word(ACT_ADVANCE, 10'd1023, 32'sd0);
		send_word(ACT_SET_VEL, 10'd0, VAL_MAX);
		send_word(ACT_ADVANCE, 10'd30, 32'sd0);
		send_word(ACT_SET_POS, 10'h3ff, VAL_MIN);
		send_word(ACT_ADVANCE, 10'd1000, 32'sd0);
		send_word(ACT_SET_VEL, 10'd0, VAL_MIN);
		send_word(ACT_UNKNOWN, 10'h3ff, -32'sd1);
		send_word(ACT_SET_POS, 10'd0, VAL_MAX);
		send_word(ACT_ADVANCE, 10'd1, 32'sd0);
		send_word(ACT_SET_POS, 10'd0, 32'sd0);
		send_word(ACT_SET_VEL, 10'd0, 32'sd0);
		send_word(ACT_ADVANCE, 10'd50, 32'sd0);
		wait_drain();
	endtask

	task automatic test_snap();
		write_reg(CFG_ANCHOR, 32'h8000_0000);
		write_reg(CFG_SNAP, 32'd1);
		send_word(ACT_SET_POS, 10'd0, 32'sh0010_0000);
		send_word(ACT_ADVANCE, 10'd40, 32'sd0);
		send_word(ACT_ADVANCE, 10'd40, 32'sd0);
		wait_drain();
		write_reg(CFG_SNAP, 32'd0);
		write_reg(CFG_ANCHOR, 32'h7fff_ffff);
		send_word(ACT_ADVANCE, 10'd20, 32'sd0);
		wait_drain();
	endtask

	task automatic test_config_extremes();
		write_reg(CFG_ANCHOR, 32'd0);
		write_reg(CFG_EPSILON, 32'd0);
		write_reg(CFG_SPRING, 32'h7fff_ffff);
		write_reg(CFG_DAMPING, 32'h7fff_ffff);
		write_reg(CFG_STEP, 32'hff_ffff);
		write_reg(CFG_RATE, 32'd65535);
		send_word(ACT_SET_POS, 10'd0, 32'sh0001_0000);
		send_word(ACT_ADVANCE, 10'd3, 32'sd0);
		wait_drain();
		write_reg(CFG_SPRING, 32'd0);
		write_reg(CFG_DAMPING, 32'd0);
		write_reg(CFG_STEP, 32'd1);
		write_reg(CFG_RATE, 32'd1);
		send_word(ACT_SET_VEL, 10'd0, 32'sh0003_0000);
		send_word(ACT_ADVANCE, 10'd1000, 32'sd0);
		send_word(ACT_ADVANCE, 10'd1000, 32'sd0);
		wait_drain();
		write_reg(CFG_EPSILON, 32'h7fff_ffff);
		write_reg(CFG_RATE, 32'd65535);
		send_word(ACT_ADVANCE, 10'd1000, 32'sd0);
		wait_drain();
		// restore the mild reset-value spring for the last words of this test
		write_reg(CFG_EPSILON, 32'd65536);
		write_reg(CFG_SPRING, 32'd13107200);
		write_reg(CFG_DAMPING, 32'd2039034);
		write_reg(CFG_STEP, 32'd167772);
		write_reg(CFG_RATE, 32'd6554);
		send_word(ACT_SET_POS, 10'd0, 32'sh0020_0000);
		send_word(ACT_ADVANCE, 10'd1000, 32'sd0);
		wait_drain();
	endtask

	task automatic random_config();
		write_reg(CFG_ANCHOR, $urandom_range(0, 3) == 0 ? $urandom() :
			32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000));
		write_reg(CFG_EPSILON, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h2_0000));
		write_reg(CFG_SPRING, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0200_0000));
		write_reg(CFG_DAMPING, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0040_0000));
		write_reg(CFG_STEP, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 32'h8_0000));
		write_reg(CFG_RATE, $urandom_range(1, 20000));
		write_reg(CFG_SNAP, 32'($urandom_range(0, 7) == 0));
	endtask

	task automatic test_random(input int words);
		int sent, n;
		logic [MS_W-1:0] ms;
		sent = 0;
		while (sent < words) begin
			if (sent % 60 == 0) begin
				wait_drain();
				random_config();
				no_gaps = $urandom_range(0, 3) == 0;
				no_stall = $urandom_range(0, 3) == 0;
			end
			if ($urandom_range(0, 4) == 0) begin
				// noise
				send_word(2'($urandom_range(0, 3)), 10'($urandom()), $urandom());
				sent++;
			end else begin
				send_word(ACT_SET_POS, 10'($urandom()),
					$urandom_range(0, 2) == 0 ? $urandom() :
					32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000));
				if ($urandom_range(0, 1))
					send_word(ACT_SET_VEL, 10'($urandom()), $urandom());
				sent += 2;
				n = $urandom_range(2, 8);
				repeat (n) begin
					ms = ($urandom_range(0, 15) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 60));
					send_word(ACT_ADVANCE, ms, $urandom());
					sent++;
				end
			end
			if (sent > words / 2 && sent < words / 2 + 10)
				wait_drain();
		end
		wait_drain();
	endtask

	initial begin
		fail_count = 0;
		burst_left = 0;
		no_gaps = 0;
		no_stall = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_ADVANCE;
		delta_ms = '0;
		set_value = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ANCHOR;
		cfg_data = '0;
		r_anchor = 0;
		r_eps = 65536;
		r_k = 13107200;
		r_c = 2039034;
		r_h = 167772;
		r_rate = 6554;
		r_snap = 0;
		s_prev_pos = 0;
		s_prev_vel = 0;
		s_next_pos = 0;
		s_next_vel = 0;
		s_phase = Q_ONE;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_directed_defaults();
		test_snap();
		test_config_extremes();
		test_random(240);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
rtl/sdra_pkg.sv
rtl/sdra_datapath.sv
rtl/sdra_ctrl.sv
rtl/spring_damper_rk4_animator.sv
rtl/sdra_checker.sv
tb/sv/spring_damper_rk4_animator_test.sv
